/* sv/mst_pkg.sv */
// Package for the methylation site tally: field widths, base codes,
// command codes and fixed-point constants. No dependencies.
`default_nettype none

package mst_pkg;

  localparam int POS_W       = 32;
  localparam int BASE_W      = 3;
  localparam int SITE_W      = 33;
  localparam int OUT_COUNT_W = 16;
  localparam int RATIO_W     = 15;

  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T = 3'd3;

  localparam logic [RATIO_W-1:0] PCT_Q8 = 15'd25600;

  typedef enum logic {
    CMD_TALLY = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

/* sv/mst_front.sv */
// Front end: accepts items, maps each position to a table slot and does the
// read-modify-write of the site table; evicted slots go to the queue.
// Depends on mst_pkg.
`default_nettype none

module mst_front #(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  input  wire logic                                  q_full,
  input  wire logic                                  cmd,
  input  wire logic [mst_pkg::POS_W-1:0]             ref_pos,
  input  wire logic [mst_pkg::BASE_W-1:0]            ref_base,
  input  wire logic [mst_pkg::BASE_W-1:0]            read_base,
  input  wire logic                                  minus_strand,
  output logic                                       full,
  output logic                                       q_push,
  output logic [mst_pkg::SITE_W+2*COUNT_BITS-1:0]    q_data
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WORD_W = mst_pkg::SITE_W + 2 * COUNT_BITS;
  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam longint unsigned RECIP_L = 64'h1_0000_0000 / TABLE_DEPTH;
  localparam logic [31:0] RECIP = RECIP_L[31:0];

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MODA,
    S_MODB,
    S_MODC,
    S_EXEC
  } state_t;

  state_t state;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] slot_idx;
  logic [31:0] qe;
  logic [IDX_W:0] rem;

  logic item_cmd;
  logic [mst_pkg::POS_W-1:0] item_pos;
  logic [mst_pkg::BASE_W-1:0] item_ref;
  logic [mst_pkg::BASE_W-1:0] item_read;
  logic item_minus;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_word;

  logic accept;
  logic rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [63:0] recip_prod;
  logic [31:0] dep_prod;
  logic [IDX_W:0] mod_full;
  logic [IDX_W-1:0] mod_idx;

  logic we;
  logic [IDX_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_word;
  logic evict;
  logic [mst_pkg::SITE_W-1:0] o_site;
  logic [mst_pkg::SITE_W-1:0] new_site;
  logic [COUNT_BITS-1:0] o_m;
  logic [COUNT_BITS-1:0] o_u;
  logic [COUNT_BITS-1:0] m_base;
  logic [COUNT_BITS-1:0] u_base;
  logic [COUNT_BITS-1:0] m_new;
  logic [COUNT_BITS-1:0] u_new;
  logic [mst_pkg::BASE_W-1:0] meth;
  logic [mst_pkg::BASE_W-1:0] unmeth;

  assign full   = (state != S_IDLE) || q_full;
  assign accept = push && !full;

  assign recip_prod = {32'b0, item_pos} * {32'b0, RECIP};
  assign dep_prod   = qe * 32'(TABLE_DEPTH);
  assign mod_full   = (rem >= (IDX_W+1)'(TABLE_DEPTH)) ?
                      rem - (IDX_W+1)'(TABLE_DEPTH) : rem;
  assign mod_idx    = mod_full[IDX_W-1:0];

  assign rd_en   = (accept && IS_POW2) || (state == S_MODC);
  assign rd_addr = (state == S_MODC) ? mod_idx : ref_pos[IDX_W-1:0];

  always_comb begin
    o_site   = rd_word[WORD_W-1 -: mst_pkg::SITE_W];
    o_m      = rd_word[2*COUNT_BITS-1 -: COUNT_BITS];
    o_u      = rd_word[COUNT_BITS-1:0];
    meth     = item_minus ? mst_pkg::BASE_G : mst_pkg::BASE_C;
    unmeth   = item_minus ? mst_pkg::BASE_A : mst_pkg::BASE_T;
    new_site = mst_pkg::SITE_W'(item_pos) + mst_pkg::SITE_W'(1);
    evict    = 1'b0;
    we       = 1'b0;
    wr_addr  = slot_idx;
    wr_word  = '0;
    m_base   = o_m;
    u_base   = o_u;
    m_new    = o_m;
    u_new    = o_u;
    case (state)
      S_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_addr;
      end
      S_EXEC: begin
        if (item_cmd == mst_pkg::CMD_DRAIN) begin
          evict = (o_site != '0) && ((o_m != '0) || (o_u != '0));
          we    = 1'b1;
        end else if (item_ref == meth) begin
          evict  = (o_site != '0) && (o_site != new_site);
          m_base = evict ? '0 : o_m;
          u_base = evict ? '0 : o_u;
          m_new  = ((item_read == meth) && (m_base != '1)) ?
                   m_base + COUNT_BITS'(1) : m_base;
          u_new  = ((item_read == unmeth) && (u_base != '1)) ?
                   u_base + COUNT_BITS'(1) : u_base;
          we      = 1'b1;
          wr_word = {new_site, m_new, u_new};
        end
      end
      default: begin
      end
    endcase
  end

  assign q_push = evict;
  assign q_data = rd_word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_cmd   <= cmd;
            item_pos   <= ref_pos;
            item_ref   <= ref_base;
            item_read  <= read_base;
            item_minus <= minus_strand;
            slot_idx   <= ref_pos[IDX_W-1:0];
            state      <= IS_POW2 ? S_EXEC : S_MODA;
          end
        end
        S_MODA: begin
          qe    <= recip_prod[63:32];
          state <= S_MODB;
        end
        S_MODB: begin
          rem   <= item_pos[IDX_W:0] - dep_prod[IDX_W:0];
          state <= S_MODC;
        end
        S_MODC: begin
          slot_idx <= mod_idx;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/mst_queue.sv */
// Short queue of evicted slots between the table front end and the ratio
// back end. No package dependencies.
`default_nettype none

module mst_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] buffer [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0] fill;
  logic do_push;
  logic do_pop;

  assign full    = fill == (PTR_W+1)'(DEPTH);
  assign empty   = fill == '0;
  assign rdata   = buffer[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      buffer[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (PTR_W+1)'(1);
        2'b01:   fill <= fill - (PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/mst_back.sv */
// Back end: takes evicted slots from the queue, works out the Q8 percentage
// with a one-bit-per-cycle divider and holds the result item for the reader.
// Depends on mst_pkg.
`default_nettype none

module mst_back #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_empty,
  input  wire logic [mst_pkg::SITE_W+2*COUNT_BITS-1:0] q_data,
  output logic                                       q_pop,
  input  wire logic                                  pop,
  output logic                                       empty,
  output logic [mst_pkg::SITE_W-1:0]                 site_pos,
  output logic [mst_pkg::OUT_COUNT_W-1:0]            methyl_count,
  output logic [mst_pkg::RATIO_W-1:0]                ratio_pct_q8
);

  localparam int TW    = COUNT_BITS + 1;
  localparam int NW    = COUNT_BITS + mst_pkg::RATIO_W;
  localparam int RW    = mst_pkg::RATIO_W;
  localparam int CNT_W = $clog2(RW);
  localparam int MW    = (COUNT_BITS > mst_pkg::OUT_COUNT_W) ?
                         COUNT_BITS : mst_pkg::OUT_COUNT_W;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_DIV,
    B_OUT
  } bstate_t;

  bstate_t state;
  logic out_valid;
  logic [mst_pkg::SITE_W-1:0] site;
  logic [COUNT_BITS-1:0] m;
  logic [COUNT_BITS-1:0] u;
  logic [NW-1:0] prod;
  logic [TW-1:0] tot;
  logic [TW-1:0] rem;
  logic [RW-1:0] low;
  logic [RW-1:0] quo;
  logic [CNT_W-1:0] cnt;

  logic [NW-1:0] num;
  logic [TW:0] shifted;
  logic take;
  logic [MW-1:0] m_wide;
  logic [mst_pkg::OUT_COUNT_W-1:0] m_sat;
  logic load;

  assign num     = prod + NW'(tot[TW-1:1]);
  assign shifted = {rem, low[RW-1]};
  assign take    = shifted >= {1'b0, tot};
  assign m_wide  = MW'(m);
  assign m_sat   = (m_wide > MW'({mst_pkg::OUT_COUNT_W{1'b1}})) ?
                   '1 : m_wide[mst_pkg::OUT_COUNT_W-1:0];
  assign load    = (state == B_OUT) && (!out_valid || pop);
  assign q_pop   = (state == B_IDLE) && !q_empty;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            site  <= q_data[mst_pkg::SITE_W+2*COUNT_BITS-1 -: mst_pkg::SITE_W];
            m     <= q_data[2*COUNT_BITS-1 -: COUNT_BITS];
            u     <= q_data[COUNT_BITS-1:0];
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod  <= NW'(m) * NW'(mst_pkg::PCT_Q8);
          tot   <= TW'(m) + TW'(u);
          state <= B_ADD;
        end
        B_ADD: begin
          rem   <= TW'(num[NW-1:RW]);
          low   <= num[RW-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          rem   <= take ? TW'(shifted - {1'b0, tot}) : shifted[TW-1:0];
          low   <= {low[RW-2:0], 1'b0};
          quo   <= {quo[RW-2:0], take};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(RW - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (load) begin
            site_pos     <= site;
            methyl_count <= m_sat;
            ratio_pct_q8 <= (tot == '0) ? '0 : quo;
            state        <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/methylation_site_tally.sv */
// Channel   Direction  Handshake          Payload
// input     in         push / full        cmd, ref_pos, ref_base, read_base, minus_strand
// result    out        empty / pop        site_pos, methyl_count, ratio_pct_q8
//
// An item holds the front end for a slot read, then a write back, when
// TABLE_DEPTH is a power of two; otherwise the slot index is found first by
// reciprocal multiply. An eviction passes the back end as queue pop, multiply,
// add, 15 divider steps and output load. After reset, full stays high while the
// table is cleared one slot per cycle. full also rises when the eviction queue
// is full; a held result stalls the back end, and the input once the queue fills.
// Top level of the methylation site tally. Depends on mst_pkg, mst_front,
// mst_queue and mst_back.
`default_nettype none

module methylation_site_tally #(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              cmd,
  input  wire logic [mst_pkg::POS_W-1:0]         ref_pos,
  input  wire logic [mst_pkg::BASE_W-1:0]        ref_base,
  input  wire logic [mst_pkg::BASE_W-1:0]        read_base,
  input  wire logic                              minus_strand,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [mst_pkg::SITE_W-1:0]             site_pos,
  output logic [mst_pkg::OUT_COUNT_W-1:0]        methyl_count,
  output logic [mst_pkg::RATIO_W-1:0]            ratio_pct_q8
);

  localparam int WORD_W  = mst_pkg::SITE_W + 2 * COUNT_BITS;
  localparam int Q_DEPTH = 4;

  logic q_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic [WORD_W-1:0] q_wdata;
  logic [WORD_W-1:0] q_rdata;

  mst_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .q_full       (q_full),
    .cmd          (cmd),
    .ref_pos      (ref_pos),
    .ref_base     (ref_base),
    .read_base    (read_base),
    .minus_strand (minus_strand),
    .full         (full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  mst_queue #(
    .WIDTH (WORD_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mst_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .site_pos     (site_pos),
    .methyl_count (methyl_count),
    .ratio_pct_q8 (ratio_pct_q8)
  );

  a_clear_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input taken during table clear");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("eviction pushed into a full queue");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ratio_pct_q8 <= mst_pkg::PCT_Q8)
    else $error("ratio above one hundred percent");

  a_site_one_based: assert property (@(posedge clk) disable iff (rst)
    !empty |-> site_pos != '0)
    else $error("result item for an empty slot");

endmodule

`default_nettype wire

/* tb/tb_methylation_site_tally.sv */
// Testbench for methylation_site_tally: directed and random base streams with
// a slot-table predictor, random push and pop gaps and field-by-field checks.
// Depends on mst_pkg and methylation_site_tally.
`timescale 1ns / 100ps

module tb_methylation_site_tally;

  localparam int TABLE_DEPTH = 256;
  localparam int COUNT_BITS  = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [mst_pkg::BASE_W-1:0] BASE_OTHER = 3'd4;
  localparam logic [mst_pkg::BASE_W-1:0] BASE_BAD   = 3'd7;
  localparam logic PLUS  = 1'b0;
  localparam logic MINUS = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [mst_pkg::SITE_W-1:0]      site;
    logic [mst_pkg::OUT_COUNT_W-1:0] methyl;
    logic [mst_pkg::RATIO_W-1:0]     ratio;
  } site_call_t;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic cmd = 1'b0;
  logic [mst_pkg::POS_W-1:0] ref_pos = '0;
  logic [mst_pkg::BASE_W-1:0] ref_base = '0;
  logic [mst_pkg::BASE_W-1:0] read_base = '0;
  logic minus_strand = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [mst_pkg::SITE_W-1:0] site_pos;
  logic [mst_pkg::OUT_COUNT_W-1:0] methyl_count;
  logic [mst_pkg::RATIO_W-1:0] ratio_pct_q8;

  logic [mst_pkg::SITE_W-1:0] held_site [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] meth_tally [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] unmeth_tally [TABLE_DEPTH];
  site_call_t pending_calls[$];
  int failures = 0;
  bit steady = 1'b0;

  methylation_site_tally #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void report_site(int unsigned idx);
    longint unsigned m, total, q;
    site_call_t call;
    m = meth_tally[idx];
    total = m + unmeth_tally[idx];
    q = (total == 0) ? 0 : (m * mst_pkg::PCT_Q8 + total / 2) / total;
    call.site = held_site[idx];
    call.methyl = meth_tally[idx];
    call.ratio = q[mst_pkg::RATIO_W-1:0];
    pending_calls.insert(pending_calls.size(), call);
  endfunction

  function automatic void free_slot(int unsigned idx);
    held_site[idx] = '0;
    meth_tally[idx] = '0;
    unmeth_tally[idx] = '0;
  endfunction

  function automatic void tally_base(mst_pkg::cmd_t c, logic [mst_pkg::POS_W-1:0] pos,
                                     logic [mst_pkg::BASE_W-1:0] rb,
                                     logic [mst_pkg::BASE_W-1:0] qb, logic ms);
    int unsigned idx;
    logic [mst_pkg::SITE_W-1:0] site;
    logic [mst_pkg::BASE_W-1:0] meth, unmeth;
    idx = pos % TABLE_DEPTH;
    site = {1'b0, pos} + 1'b1;
    meth = ms ? mst_pkg::BASE_G : mst_pkg::BASE_C;
    unmeth = ms ? mst_pkg::BASE_A : mst_pkg::BASE_T;
    if (c == mst_pkg::CMD_DRAIN) begin
      if (held_site[idx] != '0 && (meth_tally[idx] != '0 || unmeth_tally[idx] != '0))
        report_site(idx);
      free_slot(idx);
      return;
    end
    if (rb != meth) return;
    if (held_site[idx] == '0) begin
      held_site[idx] = site;
    end else if (held_site[idx] != site) begin
      report_site(idx);
      free_slot(idx);
      held_site[idx] = site;
    end
    if (qb == meth) begin
      if (meth_tally[idx] != COUNT_MAX) meth_tally[idx]++;
    end else if (qb == unmeth) begin
      if (unmeth_tally[idx] != COUNT_MAX) unmeth_tally[idx]++;
    end
  endfunction

  task automatic send_item(mst_pkg::cmd_t c, logic [mst_pkg::POS_W-1:0] p,
                           logic [mst_pkg::BASE_W-1:0] rb,
                           logic [mst_pkg::BASE_W-1:0] qb, logic ms);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    ref_pos <= p;
    ref_base <= rb;
    read_base <= qb;
    minus_strand <= ms;
    do @(posedge clk); while (full);
    tally_base(c, p, rb, qb, ms);
  endtask

  // hold the sender until every pending call has come back
  task automatic wait_for_calls();
    push <= 1'b0;
    do @(posedge clk); while (pending_calls.size() != 0);
  endtask

  task automatic test_plus_minus_calls();
    send_item(mst_pkg::CMD_TALLY, 32'd0, mst_pkg::BASE_C, mst_pkg::BASE_C, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd0, mst_pkg::BASE_C, mst_pkg::BASE_C, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd0, mst_pkg::BASE_C, mst_pkg::BASE_T, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd0, mst_pkg::BASE_C, mst_pkg::BASE_A, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd256, mst_pkg::BASE_G, mst_pkg::BASE_G, MINUS);
    send_item(mst_pkg::CMD_TALLY, 32'd256, mst_pkg::BASE_G, mst_pkg::BASE_A, MINUS);
    send_item(mst_pkg::CMD_TALLY, 32'd256, mst_pkg::BASE_G, mst_pkg::BASE_C, MINUS);
  endtask

  task automatic test_ignored_bases();
    send_item(mst_pkg::CMD_TALLY, 32'd256, mst_pkg::BASE_G, mst_pkg::BASE_G, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd256, mst_pkg::BASE_C, mst_pkg::BASE_C, MINUS);
    send_item(mst_pkg::CMD_TALLY, 32'd512, BASE_OTHER, mst_pkg::BASE_C, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd512, BASE_BAD, mst_pkg::BASE_G, MINUS);
  endtask

  task automatic test_claim_without_count();
    send_item(mst_pkg::CMD_TALLY, 32'd5, mst_pkg::BASE_C, BASE_OTHER, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd261, mst_pkg::BASE_C, mst_pkg::BASE_C, PLUS);
  endtask

  task automatic test_drain_cases();
    send_item(mst_pkg::CMD_DRAIN, 32'd261, mst_pkg::BASE_A, mst_pkg::BASE_A, PLUS);
    send_item(mst_pkg::CMD_DRAIN, 32'd9, mst_pkg::BASE_C, mst_pkg::BASE_C, PLUS);
    send_item(mst_pkg::CMD_TALLY, 32'd10, mst_pkg::BASE_C, BASE_BAD, PLUS);
    send_item(mst_pkg::CMD_DRAIN, 32'd10, mst_pkg::BASE_C, mst_pkg::BASE_C, PLUS);
    send_item(mst_pkg::CMD_DRAIN, 32'd256, mst_pkg::BASE_G, mst_pkg::BASE_G, MINUS);
  endtask

  task automatic test_position_extremes();
    send_item(mst_pkg::CMD_TALLY, 32'hFFFF_FFFF, mst_pkg::BASE_G, mst_pkg::BASE_G, MINUS);
    send_item(mst_pkg::CMD_TALLY, 32'h7FFF_FFFF, mst_pkg::BASE_G, mst_pkg::BASE_A, MINUS);
    send_item(mst_pkg::CMD_DRAIN, 32'hFFFF_FFFF, BASE_BAD, BASE_BAD, MINUS);
  endtask

  task automatic test_random_stream();
    logic [mst_pkg::POS_W-1:0] p;
    logic [mst_pkg::BASE_W-1:0] rb, qb;
    logic ms;
    mst_pkg::cmd_t c;
    int r;
    logic [23:0] upper [3];
    upper[0] = 24'h000000;
    upper[1] = 24'hFFFFFF;
    upper[2] = 24'($urandom());
    for (int i = 0; i < 500; i++) begin
      steady = (i % 160) < 30;
      if (i == 250) wait_for_calls();
      r = $urandom_range(0, 99);
      ms = 1'($urandom_range(0, 1));
      c = mst_pkg::CMD_TALLY;
      p = {upper[$urandom_range(0, 2)], 8'($urandom_range(0, 11))};
      rb = ms ? mst_pkg::BASE_G : mst_pkg::BASE_C;
      qb = $urandom_range(0, 99) < 50 ? rb : (ms ? mst_pkg::BASE_A : mst_pkg::BASE_T);
      if ($urandom_range(0, 99) < 15) qb = 3'($urandom_range(0, 7));
      if (r < 6) begin
        c = mst_pkg::CMD_DRAIN;
      end else if (r < 16) begin
        p = $urandom();
        rb = 3'($urandom_range(0, 7));
        qb = 3'($urandom_range(0, 7));
      end
      send_item(c, p, rb, qb, ms);
    end
    steady = 1'b0;
  endtask

  task automatic test_final_drain();
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (held_site[i] != '0)
        send_item(mst_pkg::CMD_DRAIN, {24'($urandom()), 8'(i)}, 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  initial begin : result_check
    site_call_t want;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_calls.size() == 0) begin
          $error("unexpected item: site_pos %0d", site_pos);
          failures++;
        end else begin
          want = pending_calls.pop_front();
          if (site_pos !== want.site) begin
            $error("site_pos: expected %0d, got %0d", want.site, site_pos);
            failures++;
          end
          if (methyl_count !== want.methyl) begin
            $error("methyl_count: expected %0d, got %0d", want.methyl, methyl_count);
            failures++;
          end
          if (ratio_pct_q8 !== want.ratio) begin
            $error("ratio_pct_q8: expected %0d, got %0d", want.ratio, ratio_pct_q8);
            failures++;
          end
        end
      end
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) free_slot(i);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plus_minus_calls();
    test_ignored_bases();
    test_claim_without_count();
    test_drain_cases();
    wait_for_calls();
    test_position_extremes();
    test_random_stream();
    test_final_drain();
    wait_for_calls();
    repeat (40) @(posedge clk);
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
